/* hw/rtl/bit_file_header_parser_top_defines.svh */
// Assertion macros shared by the header parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BIT_FILE_HEADER_PARSER_TOP_DEFINES_SVH
`define BIT_FILE_HEADER_PARSER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is held low
`define BFHP_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) else $error(msg);

// Clocked assertion that also holds through reset
`define BFHP_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

/* hw/rtl/bfhp_pkg.sv */
// Types and constants for the configuration file header parser.
// No dependencies; imported by every module of the block.
package bfhp_pkg;

  // Parse phases
  typedef enum logic [3:0] {
    PH_PRE_HI   = 4'd0,
    PH_PRE_LO   = 4'd1,
    PH_PRE_SKIP = 4'd2,
    PH_CNT_HI   = 4'd3,
    PH_CNT_LO   = 4'd4,
    PH_TAG      = 4'd5,
    PH_LEN_HI   = 4'd6,
    PH_LEN_LO   = 4'd7,
    PH_PAYLOAD  = 4'd8,
    PH_DSIZE    = 4'd9,
    PH_STREAM   = 4'd10
  } bfhp_phase_t;

  // Role of a byte in the file
  typedef enum logic [2:0] {
    KIND_PRE_LEN   = 3'd0,
    KIND_PRE_SKIP  = 3'd1,
    KIND_COUNT     = 3'd2,
    KIND_TAG       = 3'd3,
    KIND_FIELD_LEN = 3'd4,
    KIND_PAYLOAD   = 3'd5,
    KIND_DATA_SIZE = 3'd6,
    KIND_BITSTREAM = 3'd7
  } bfhp_kind_t;

  localparam logic [7:0]  END_TAG     = 8'h65;
  localparam logic [23:0] HDR_MAX     = 24'hFF_FFFF;
  localparam logic [15:0] DSIZE_BYTES = 16'd4;
  localparam int          RESULT_W    = 89;
  localparam int          OUT_DATA_W  = 96;

  // Classified byte handed from the front end to the back end
  typedef struct packed {
    logic       restart;
    logic       end_tag;
    logic [7:0] data;
  } bfhp_item_t;

  // Result payload; first member sits in the highest bits
  typedef struct packed {
    logic [31:0] data_size;
    logic [23:0] header_size;
    logic        header_done;
    logic [15:0] field_length;
    logic [7:0]  byte_out;
    logic [7:0]  current_tag;
  } bfhp_result_t;

endpackage

/* hw/rtl/bfhp_front.sv */
// Input stage: registers each byte and flags the end tag.
// Depends on bfhp_pkg.
module bfhp_front
  import bfhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_restart,
  input  logic [7:0] in_byte,
  output logic       item_valid,
  input  logic       item_ready,
  output bfhp_item_t item
);

  logic       valid_r;
  bfhp_item_t item_r;

  // Take a new beat whenever the stage is empty or drains this cycle
  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (item_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture and classify the byte
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.restart <= in_restart;
      item_r.end_tag <= (in_byte == END_TAG);
      item_r.data    <= in_byte;
    end
  end

endmodule

/* hw/rtl/bfhp_queue.sv */
// Small FIFO between the front and back ends of the parser.
// Depends on bfhp_pkg and the assertion macro header.
`include "bit_file_header_parser_top_defines.svh"
module bfhp_queue
  import bfhp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  bfhp_item_t wr_item,
  output logic       rd_valid,
  input  logic       rd_ready,
  output bfhp_item_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bfhp_item_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `BFHP_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= FULL_CNT, "queue count above depth")
  `BFHP_ASSERT(a_cnt_up, clk, rst_n,
               (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1),
               "queue count did not rise on push")
  `BFHP_ASSERT(a_cnt_down, clk, rst_n,
               (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1),
               "queue count did not fall on pop")

endmodule

/* hw/rtl/bfhp_back.sv */
// Parse engine: steps the header state per byte and holds the result beat.
// Depends on bfhp_pkg and the assertion macro header.
`include "bit_file_header_parser_top_defines.svh"
module bfhp_back
  import bfhp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  output logic         item_ready,
  input  bfhp_item_t   item,
  output logic         out_valid,
  input  logic         out_ready,
  output bfhp_kind_t   out_kind,
  output bfhp_result_t out_result
);

  bfhp_phase_t  phase_r, phase_nxt, ph_eff;
  logic [15:0]  bcnt_r, bcnt_nxt, bcnt_eff;
  logic [31:0]  acc_r, acc_nxt, acc_eff;
  logic [7:0]   tag_r, tag_nxt, tag_eff;
  logic [23:0]  hdr_r, hdr_nxt, hdr_eff;
  logic [31:0]  dsize_r, dsize_nxt, dsize_eff;
  bfhp_kind_t   kind;
  logic [15:0]  flen;
  logic         pop;
  logic         out_valid_r;
  bfhp_kind_t   out_kind_r;
  bfhp_result_t out_result_r;

  assign item_ready = !out_valid_r || out_ready;
  assign pop        = item_valid && item_ready;
  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_result = out_result_r;

  // Drop the old parse on a restart byte
  always_comb begin
    if (item.restart) begin
      ph_eff    = PH_PRE_HI;
      bcnt_eff  = '0;
      acc_eff   = '0;
      tag_eff   = '0;
      hdr_eff   = '0;
      dsize_eff = '0;
    end else begin
      ph_eff    = phase_r;
      bcnt_eff  = bcnt_r;
      acc_eff   = acc_r;
      tag_eff   = tag_r;
      hdr_eff   = hdr_r;
      dsize_eff = dsize_r;
    end
  end

  // Byte role and reported field length
  always_comb begin
    flen = '0;
    case (ph_eff)
      PH_PRE_HI: begin
        kind = KIND_PRE_LEN;
      end
      PH_PRE_LO: begin
        kind = KIND_PRE_LEN;
        flen = {acc_eff[15:8], item.data};
      end
      PH_PRE_SKIP: begin
        kind = KIND_PRE_SKIP;
        flen = acc_eff[15:0];
      end
      PH_CNT_HI: begin
        kind = KIND_COUNT;
      end
      PH_CNT_LO: begin
        kind = KIND_COUNT;
        flen = {acc_eff[15:8], item.data};
      end
      PH_TAG: begin
        kind = KIND_TAG;
      end
      PH_LEN_HI: begin
        kind = KIND_FIELD_LEN;
      end
      PH_LEN_LO: begin
        kind = KIND_FIELD_LEN;
        flen = {acc_eff[15:8], item.data};
      end
      PH_PAYLOAD: begin
        kind = KIND_PAYLOAD;
        flen = acc_eff[15:0];
      end
      PH_DSIZE: begin
        kind = KIND_DATA_SIZE;
      end
      default: begin
        kind = KIND_BITSTREAM;
      end
    endcase
  end

  // Next parse state
  always_comb begin
    logic [15:0] lo16;
    logic [15:0] bcnt_dec;
    logic [15:0] bcnt_inc;
    lo16      = {acc_eff[15:8], item.data};
    bcnt_dec  = bcnt_eff - 1'b1;
    bcnt_inc  = bcnt_eff + 1'b1;
    phase_nxt = ph_eff;
    bcnt_nxt  = bcnt_eff;
    acc_nxt   = acc_eff;
    tag_nxt   = tag_eff;
    dsize_nxt = dsize_eff;
    case (ph_eff)
      PH_PRE_HI: begin
        acc_nxt   = {16'd0, item.data, 8'd0};
        phase_nxt = PH_PRE_LO;
      end
      PH_PRE_LO: begin
        acc_nxt   = {16'd0, lo16};
        bcnt_nxt  = lo16;
        phase_nxt = (lo16 == '0) ? PH_CNT_HI : PH_PRE_SKIP;
      end
      PH_PRE_SKIP: begin
        bcnt_nxt = bcnt_dec;
        if (bcnt_dec == '0) begin
          phase_nxt = PH_CNT_HI;
        end
      end
      PH_CNT_HI: begin
        acc_nxt   = {16'd0, item.data, 8'd0};
        phase_nxt = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        acc_nxt   = {16'd0, lo16};
        phase_nxt = PH_TAG;
      end
      PH_TAG: begin
        tag_nxt = item.data;
        if (item.end_tag) begin
          acc_nxt   = '0;
          bcnt_nxt  = '0;
          phase_nxt = PH_DSIZE;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        acc_nxt   = {16'd0, item.data, 8'd0};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        acc_nxt   = {16'd0, lo16};
        bcnt_nxt  = lo16;
        phase_nxt = (lo16 == '0) ? PH_TAG : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        bcnt_nxt = bcnt_dec;
        if (bcnt_dec == '0) begin
          phase_nxt = PH_TAG;
        end
      end
      PH_DSIZE: begin
        acc_nxt  = {acc_eff[23:0], item.data};
        bcnt_nxt = bcnt_inc;
        if (bcnt_inc >= DSIZE_BYTES) begin
          dsize_nxt = {acc_eff[23:0], item.data};
          phase_nxt = PH_STREAM;
        end
      end
      default: begin
        phase_nxt = PH_STREAM;
      end
    endcase
    // Count header bytes, holding at the top value
    if (kind != KIND_BITSTREAM && hdr_eff != HDR_MAX) begin
      hdr_nxt = hdr_eff + 1'b1;
    end else begin
      hdr_nxt = hdr_eff;
    end
  end

  // Commit parse state on each consumed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRE_HI;
      bcnt_r  <= '0;
      acc_r   <= '0;
      tag_r   <= '0;
      hdr_r   <= '0;
      dsize_r <= '0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      acc_r   <= acc_nxt;
      tag_r   <= tag_nxt;
      hdr_r   <= hdr_nxt;
      dsize_r <= dsize_nxt;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind_r                <= kind;
      out_result_r.data_size    <= dsize_nxt;
      out_result_r.header_size  <= hdr_nxt;
      out_result_r.header_done  <= (phase_nxt == PH_STREAM);
      out_result_r.field_length <= flen;
      out_result_r.byte_out     <= item.data;
      out_result_r.current_tag  <= tag_nxt;
    end
  end

  `BFHP_ASSERT(a_skip_pending, clk, rst_n, (phase_r == PH_PRE_SKIP || phase_r == PH_PAYLOAD) |-> (bcnt_r != '0), "skip phase with nothing left to skip")
  `BFHP_ASSERT(a_dsize_bound, clk, rst_n, (phase_r == PH_DSIZE) |-> (bcnt_r < DSIZE_BYTES), "data size byte count overran")
  `BFHP_ASSERT(a_stream_sticks, clk, rst_n, (pop && phase_r == PH_STREAM && !item.restart) |=> (phase_r == PH_STREAM), "left bitstream phase without restart")

endmodule

/* hw/rtl/bit_file_header_parser_top.sv */
// Header parser top: a byte passes the input stage, the queue and the output register.
// One byte per cycle while out_tready is high, set by the parse step in the back end.
// The input stage, a QUEUE_DEPTH-entry FIFO and the output register decouple both sides.
// Reset (rst_n low, synchronous) empties all stages and returns the parse to the
// preamble length; a byte with restart set does the same for the parse in band.
module bit_file_header_parser_top
  import bfhp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] restart
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] current_tag, [15:8] byte_out, [31:16] field_length, [32] header_done,
  // [56:33] header_size, [88:57] data_size, [95:89] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser   // [2:0] byte_kind
);

  logic         f_valid;
  logic         f_ready;
  bfhp_item_t   f_item;
  logic         q_valid;
  logic         q_ready;
  bfhp_item_t   q_item;
  bfhp_kind_t   kind;
  bfhp_result_t result;

  bfhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_restart (in_tuser),
    .in_byte    (in_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  bfhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  bfhp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (kind),
    .out_result (result)
  );

  // Pack the result beat
  assign out_tdata = {(OUT_DATA_W - RESULT_W)'(0), result};
  assign out_tuser = kind;

endmodule

/* tb/bit_file_header_parser_top_test.sv */
// Self-checking testbench for bit_file_header_parser_top: streams configuration files
// byte by byte and checks every tagged result beat against a local header predictor.
// Depends on bfhp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module bit_file_header_parser_top_test;
  import bfhp_pkg::*;

  localparam int FILE_BYTES  = 500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_AFTER  = 100;
  localparam int HOLD_CYCLES = 400;

  // One byte of the input file as offered to the block
  typedef struct {
    logic       restart;
    logic [7:0] data;
  } file_byte_t;

  // Expected classification of one byte
  typedef struct {
    bfhp_kind_t  kind;
    logic [7:0]  tag;
    logic [7:0]  data;
    logic [15:0] flen;
    logic        done;
    logic [23:0] hsize;
    logic [31:0] dsize;
  } tagged_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] data_byte
  logic                  in_tuser = 1'b0; // [0] restart
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [7:0] current_tag, [15:8] byte_out, [31:16] field_length, [32] header_done,
  // [56:33] header_size, [88:57] data_size, [95:89] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;       // [2:0] byte_kind

  file_byte_t   file_q[$];
  file_byte_t   file_buf[$];
  tagged_byte_t tagged_q[$];
  file_byte_t   cur_byte;
  tagged_byte_t predicted;
  tagged_byte_t seen;

  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  bit hold_done = 1'b0;

  // Parser state of the predictor
  bfhp_phase_t ph;
  logic [15:0] remaining;
  logic [31:0] len_acc;
  logic [7:0]  tag_r;
  logic [23:0] hdr_cnt;
  logic [31:0] dsize_r;

  bit_file_header_parser_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  task automatic clear_parse();
    ph        = PH_PRE_HI;
    remaining = '0;
    len_acc   = '0;
    tag_r     = '0;
    hdr_cnt   = '0;
    dsize_r   = '0;
  endtask

  // Advance the header parse by one byte and work out its classification
  task automatic classify_byte(input file_byte_t fb, output tagged_byte_t t);
    logic [15:0] flen;
    bfhp_kind_t  kind;
    flen = '0;
    if (fb.restart) clear_parse();
    case (ph)
      PH_PRE_HI: begin
        kind    = KIND_PRE_LEN;
        len_acc = {16'd0, fb.data, 8'd0};
        ph      = PH_PRE_LO;
      end
      PH_PRE_LO: begin
        kind      = KIND_PRE_LEN;
        len_acc   = {16'd0, len_acc[15:8], fb.data};
        flen      = len_acc[15:0];
        remaining = len_acc[15:0];
        ph        = (len_acc[15:0] == 16'd0) ? PH_CNT_HI : PH_PRE_SKIP;
      end
      PH_PRE_SKIP: begin
        kind      = KIND_PRE_SKIP;
        flen      = len_acc[15:0];
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) ph = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        kind    = KIND_COUNT;
        len_acc = {16'd0, fb.data, 8'd0};
        ph      = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        kind    = KIND_COUNT;
        len_acc = {16'd0, len_acc[15:8], fb.data};
        flen    = len_acc[15:0];
        ph      = PH_TAG;
      end
      PH_TAG: begin
        kind  = KIND_TAG;
        tag_r = fb.data;
        if (fb.data == END_TAG) begin
          len_acc   = '0;
          remaining = '0;
          ph        = PH_DSIZE;
        end else begin
          ph = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        kind    = KIND_FIELD_LEN;
        len_acc = {16'd0, fb.data, 8'd0};
        ph      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        kind      = KIND_FIELD_LEN;
        len_acc   = {16'd0, len_acc[15:8], fb.data};
        flen      = len_acc[15:0];
        remaining = len_acc[15:0];
        ph        = (len_acc[15:0] == 16'd0) ? PH_TAG : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        kind      = KIND_PAYLOAD;
        flen      = len_acc[15:0];
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) ph = PH_TAG;
      end
      PH_DSIZE: begin
        kind      = KIND_DATA_SIZE;
        len_acc   = {len_acc[23:0], fb.data};
        remaining = remaining + 16'd1;
        if (remaining >= DSIZE_BYTES) begin
          dsize_r = len_acc;
          ph      = PH_STREAM;
        end
      end
      default: begin
        kind = KIND_BITSTREAM;
        ph   = PH_STREAM;
      end
    endcase
    if (kind != KIND_BITSTREAM && hdr_cnt != HDR_MAX) hdr_cnt = hdr_cnt + 24'd1;
    t.kind  = kind;
    t.tag   = tag_r;
    t.data  = fb.data;
    t.flen  = flen;
    t.done  = (ph == PH_STREAM);
    t.hsize = hdr_cnt;
    t.dsize = dsize_r;
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_byte(input logic restart, input logic [7:0] data);
    file_byte_t fb;
    fb.restart = restart;
    fb.data    = data;
    file_buf.push_back(fb);
  endtask

  task automatic put_word16(input logic [15:0] w);
    put_byte(1'b0, w[15:8]);
    put_byte(1'b0, w[7:0]);
  endtask

  // Move the first keep bytes of the assembled file to the send queue
  task automatic flush_file(input int keep);
    for (int i = 0; i < keep; i++) file_q.push_back(file_buf[i]);
    file_buf.delete();
  endtask

  // Assemble one random file: mostly well formed, some cut short, some plain noise
  task automatic add_file(input bit big);
    int          roll;
    int          pre_len;
    int          nrec;
    int          rlen;
    logic [7:0]  tg;
    logic [31:0] ds;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      repeat ($urandom_range(1, 20))
        put_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
    end else begin
      pre_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      put_word16(16'(pre_len));
      repeat (pre_len) put_byte(1'b0, 8'($urandom_range(0, 255)));
      put_word16(16'($urandom_range(0, 65535)));
      nrec = $urandom_range(0, 4);
      for (int i = 0; i < nrec; i++) begin
        tg = 8'($urandom_range(0, 255));
        if (tg == END_TAG) tg = 8'h00;
        if (big && i == 0) rlen = 256 + $urandom_range(0, 31);
        else rlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        put_byte(1'b0, tg);
        put_word16(16'(rlen));
        repeat (rlen) put_byte(1'b0, 8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 5))
        0:       ds = '0;
        1:       ds = '1;
        default: ds = 32'($urandom());
      endcase
      put_byte(1'b0, END_TAG);
      for (int i = 3; i >= 0; i--) put_byte(1'b0, ds[8*i +: 8]);
      repeat ($urandom_range(0, 8)) put_byte(1'b0, 8'($urandom_range(0, 255)));
    end
    file_buf[0].restart = 1'b1;
    // cut short: the next file's restart lands mid-parse
    flush_file((roll == 1) ? $urandom_range(1, file_buf.size()) : file_buf.size());
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sender: offer queued bytes with random gaps, predict each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      send_gap  <= 0;
      clear_parse();
    end else begin
      if (in_tvalid && in_tready) begin
        classify_byte(cur_byte, predicted);
        tagged_q.push_back(predicted);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0 || file_q.size() == 0) begin
          in_tvalid <= 1'b0;
          if (send_gap != 0) send_gap <= send_gap - 1;
        end else begin
          cur_byte  = file_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_byte.data;
          in_tuser  <= cur_byte.restart;
          if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
          send_gap <= send_steady ? 0 : pick_gap();
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall != 0) begin
      out_tready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
      recv_stall <= HOLD_CYCLES;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 49) == 0) recv_steady = !recv_steady;
      recv_stall <= recv_steady ? 0 : pick_gap();
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (tagged_q.size() == 0) begin
        $error("result beat with no byte outstanding");
        errors++;
      end else begin
        seen = tagged_q.pop_front();
        compare_field("byte_kind", 32'(seen.kind), 32'(out_tuser));
        compare_field("current_tag", 32'(seen.tag), 32'(out_tdata[7:0]));
        compare_field("byte_out", 32'(seen.data), 32'(out_tdata[15:8]));
        compare_field("field_length", 32'(seen.flen), 32'(out_tdata[31:16]));
        compare_field("header_done", 32'(seen.done), 32'(out_tdata[32]));
        compare_field("header_size", 32'(seen.hsize), 32'(out_tdata[56:33]));
        compare_field("data_size", seen.dsize, out_tdata[88:57]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // Parse from reset state without restart: one-byte preamble, count with top bit
    // set, a zero-length record, a one-byte record, end tag with all-ones size
    put_word16(16'h0001);
    put_byte(1'b0, 8'hA5);
    put_word16(16'h8001);
    put_byte(1'b0, 8'h61);
    put_word16(16'h0000);
    put_byte(1'b0, 8'h62);
    put_word16(16'h0001);
    put_byte(1'b0, 8'h7F);
    put_byte(1'b0, END_TAG);
    repeat (4) put_byte(1'b0, 8'hFF);
    put_byte(1'b0, 8'h5A);
    // Restart from the bitstream: empty preamble and count, end tag straight away
    put_byte(1'b1, 8'h00);
    put_byte(1'b0, 8'h00);
    put_word16(16'h0000);
    put_byte(1'b0, END_TAG);
    put_byte(1'b0, 8'h01);
    put_byte(1'b0, 8'h02);
    put_byte(1'b0, 8'h03);
    put_byte(1'b0, 8'h04);
    put_byte(1'b0, 8'hC3);
    flush_file(file_buf.size());

    for (int n = 0; file_q.size() < FILE_BYTES; n++) add_file(n == 3);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent, every result back, then let the pipe settle
    while (file_q.size() != 0 || in_tvalid) @(posedge clk);
    while (tagged_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
